// ===== sv/carpid_pkg.sv =====
// ----------------------------------------------------------------------------
// carpid_pkg
// Shared types, constants and helpers for the cascaded attitude/rate PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package carpid_pkg;

   localparam int DATA_WIDTH_DEF = 16;

   localparam int FIELD_W    = 16;
   localparam int CSR_W      = 48;
   localparam int MODE_W     = 33;
   localparam int CSR_IDX_W  = 3;
   localparam int REQ_DATA_W = 9 * FIELD_W;
   localparam int RSP_DATA_W = 6 * FIELD_W;

   // state memory address is {kind, axis}
   localparam int STATE_ADDR_W = 4;

   // outer loop limits, Q3.12
   localparam logic [FIELD_W-1:0] ANG_45   = 16'd3217;
   localparam logic [FIELD_W-1:0] RATE_220 = 16'd15728;
   localparam logic [FIELD_W-1:0] RATE_200 = 16'd14298;

   localparam logic [CSR_IDX_W-1:0] CSR_ATT_GAINS        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_KP          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_KI_DT       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_KD_PER_DT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_LIMITS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TORQUE_LIMITS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INERTIA_PER_DT   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_COMP_MODE = 3'd7;

   localparam logic [1:0] AXIS_ROLL  = 2'd0;
   localparam logic [1:0] AXIS_PITCH = 2'd1;
   localparam logic [1:0] AXIS_YAW   = 2'd2;

   typedef enum logic [1:0] {
      KIND_INTEG,
      KIND_FILT,
      KIND_PFILT,
      KIND_PRC
   } state_kind_type;

   typedef struct packed {
      logic [CSR_W-1:0]  att_gains;
      logic [CSR_W-1:0]  rate_kp;
      logic [CSR_W-1:0]  rate_ki_dt;
      logic [CSR_W-1:0]  rate_kd_per_dt;
      logic [CSR_W-1:0]  integ_limits;
      logic [CSR_W-1:0]  torque_limits;
      logic [CSR_W-1:0]  inertia_per_dt;
      logic [MODE_W-1:0] filter_comp_mode;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic take;
      logic clear;
   } seq_ctrl_type;

   // multiplier operand width: widest difference fed to the shared multiplier
   function automatic int mul_x_width(input int dw);
      return (dw + 1 > 17) ? dw + 1 : 17;
   endfunction

   // rounded product width: operand plus 17-bit gain and one rounding carry bit, less twelve fraction bits
   function automatic int mul_res_width(input int dw);
      return mul_x_width(dw) + 6;
   endfunction

   // pick one axis lane out of a roll/pitch/yaw packed word
   function automatic logic [FIELD_W-1:0] lane16(input logic [CSR_W-1:0] r,
                                                 input logic [1:0] axis);
      logic [FIELD_W-1:0] v;
      case (axis)
         AXIS_ROLL:  v = r[15:0];
         AXIS_PITCH: v = r[31:16];
         default:    v = r[47:32];
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== sv/carpid_state_ram.sv =====
// ----------------------------------------------------------------------------
// carpid_state_ram
// Controller state memory: one write and one registered read per cycle.
// Entries not written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module carpid_state_ram
   import carpid_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          wr_en,
   input  wire  [STATE_ADDR_W-1:0]      wr_addr,
   input  wire  [DATA_WIDTH-1:0]        wr_data,
   input  wire  [STATE_ADDR_W-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);

   localparam int DEPTH = 2 ** STATE_ADDR_W;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/carpid_mul_round.sv =====
// ----------------------------------------------------------------------------
// carpid_mul_round
// Shared gain multiplier: registered product of an unsigned 16-bit factor and
// a signed operand, rounded half up by 12 or 16 fraction bits on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module carpid_mul_round
   import carpid_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire                                           clock,
   input  wire  [FIELD_W-1:0]                            k,
   input  wire  signed [mul_x_width(DATA_WIDTH)-1:0]     x,
   input  wire                                           shift16,
   output logic signed [mul_res_width(DATA_WIDTH)-1:0]   result
);

   localparam int XW = mul_x_width(DATA_WIDTH);
   localparam int PW = XW + FIELD_W + 1;
   localparam int MW = mul_res_width(DATA_WIDTH);

   localparam logic signed [PW:0] RND12 = {{(PW - 11){1'b0}}, 1'b1, {11{1'b0}}};
   localparam logic signed [PW:0] RND16 = {{(PW - 15){1'b0}}, 1'b1, {15{1'b0}}};

   logic signed [PW-1:0] prod_ff;
   logic                 shift16_ff;
   logic signed [PW:0]   sum;
   logic signed [PW:0]   shifted;

   always_ff @(posedge clock) begin
      prod_ff    <= $signed({1'b0, k}) * x;
      shift16_ff <= shift16;
   end

   always_comb begin
      sum     = $signed({prod_ff[PW-1], prod_ff}) + (shift16_ff ? RND16 : RND12);
      shifted = shift16_ff ? (sum >>> 16) : (sum >>> 12);
      result  = MW'(shifted);
   end

endmodule

`default_nettype wire

// ===== sv/carpid_seq.sv =====
// ----------------------------------------------------------------------------
// carpid_seq
// Per-axis sequencer: reads the axis state from memory, runs every gain
// product through the shared multiplier, writes the updated state back.
// ----------------------------------------------------------------------------
`default_nettype none

module carpid_seq
   import carpid_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire                                           clock,
   input  wire                                           reset,
   input  wire  seq_ctrl_type                            ctrl,
   input  wire  cfg_type                                 cfg,
   input  wire  [REQ_DATA_W-1:0]                         in_data,
   output logic                                          done,
   output logic [RSP_DATA_W-1:0]                         result,
   output logic                                          wr_en,
   output logic [STATE_ADDR_W-1:0]                       wr_addr,
   output logic [DATA_WIDTH-1:0]                         wr_data,
   output logic [STATE_ADDR_W-1:0]                       rd_addr,
   input  wire  [DATA_WIDTH-1:0]                         rd_data,
   output logic [FIELD_W-1:0]                            mul_k,
   output logic signed [mul_x_width(DATA_WIDTH)-1:0]     mul_x,
   output logic                                          mul_shift16,
   input  wire  signed [mul_res_width(DATA_WIDTH)-1:0]   mul_result
);

   localparam int DW = DATA_WIDTH;
   localparam int XW = mul_x_width(DATA_WIDTH);
   localparam int MW = mul_res_width(DATA_WIDTH);
   localparam int AW = MW + 2;

   localparam logic signed [DW-1:0] HI_D = {1'b0, {(DW - 1){1'b1}}};
   localparam logic signed [DW-1:0] LO_D = ~HI_D;
   localparam logic signed [AW-1:0] HI_W = AW'(HI_D);
   localparam logic signed [AW-1:0] LO_W = AW'(LO_D);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ORATE,
      S_FILT,
      S_PROP,
      S_DERIV,
      S_INTEG,
      S_FFWD,
      S_TORQUE,
      S_HYBRID,
      S_COMP,
      S_STORE,
      S_HOLD
   } seq_state_type;

   function automatic logic signed [DW-1:0] sat(input logic signed [AW-1:0] v);
      logic signed [DW-1:0] r;
      if (v > HI_W) begin
         r = HI_D;
      end else if (v < LO_W) begin
         r = LO_D;
      end else begin
         r = DW'(v);
      end
      return r;
   endfunction

   function automatic logic signed [AW-1:0] clampsym(input logic signed [AW-1:0] v,
                                                     input logic [FIELD_W-1:0] lim);
      logic signed [AW-1:0] lim_w;
      logic signed [AW-1:0] r;
      lim_w = signed'(AW'(lim));
      if (v > lim_w) begin
         r = lim_w;
      end else if (v < -lim_w) begin
         r = -lim_w;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic signed [AW-1:0] ext_dw(input logic signed [DW-1:0] v);
      return AW'(v);
   endfunction

   function automatic logic signed [AW-1:0] ext_16(input logic signed [FIELD_W-1:0] v);
      return AW'(v);
   endfunction

   seq_state_type state_ff, state_in;
   logic [1:0]    axis_ff, axis_in;

   logic signed [DW-1:0] f_ff, f_in;
   logic signed [DW-1:0] pf_ff, pf_in;
   logic signed [DW-1:0] i_ff, i_in;
   logic signed [DW-1:0] prc_ff, prc_in;
   logic signed [DW-1:0] t_ff, t_in;
   logic signed [MW:0]   acc_ff, acc_in;
   logic signed [MW-1:0] ff_ff, ff_in;
   logic [FIELD_W-1:0]   orate_ff [3];
   logic [FIELD_W-1:0]   orate_in [3];
   logic [FIELD_W-1:0]   torque_ff [3];
   logic [FIELD_W-1:0]   torque_in [3];

   logic signed [FIELD_W-1:0] att, meas, cmd;
   logic signed [AW-1:0]      att_c;
   logic signed [DW-1:0]      err;
   logic signed [DW-1:0]      rd_clr;
   logic signed [AW-1:0]      res_w;
   logic                      hybrid;

   always_comb begin
      att    = signed'(lane16(in_data[47:0], axis_ff));
      meas   = signed'(lane16(in_data[95:48], axis_ff));
      cmd    = signed'(lane16(in_data[143:96], axis_ff));
      // yaw error is already wrapped, only roll and pitch get the 45 degree clamp
      att_c  = (axis_ff == AXIS_YAW) ? ext_16(att) : clampsym(ext_16(att), ANG_45);
      err    = sat(ext_16(cmd) - ext_16(meas));
      rd_clr = ctrl.clear ? '0 : signed'(rd_data);
      res_w  = AW'(mul_result);
      hybrid = cfg.filter_comp_mode[32];
   end

   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      f_in        = f_ff;
      pf_in       = pf_ff;
      i_in        = i_ff;
      prc_in      = prc_ff;
      t_in        = t_ff;
      acc_in      = acc_ff;
      ff_in       = ff_ff;
      orate_in    = orate_ff;
      torque_in   = torque_ff;
      wr_en       = 1'b0;
      wr_addr     = {KIND_FILT, axis_ff};
      wr_data     = f_ff;
      rd_addr     = {KIND_FILT, axis_ff};
      mul_k       = '0;
      mul_x       = '0;
      mul_shift16 = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               axis_in  = AXIS_ROLL;
               state_in = S_ORATE;
            end
         end
         S_ORATE: begin
            rd_addr  = {KIND_FILT, axis_ff};
            mul_k    = lane16(cfg.att_gains, axis_ff);
            mul_x    = XW'(att_c);
            state_in = S_FILT;
         end
         S_FILT: begin
            f_in        = rd_clr;
            rd_addr     = {KIND_PFILT, axis_ff};
            mul_k       = cfg.filter_comp_mode[15:0];
            mul_x       = XW'(ext_dw(err) - ext_dw(rd_clr));
            mul_shift16 = 1'b1;
            orate_in[axis_ff] = FIELD_W'(sat(clampsym(res_w,
               (axis_ff == AXIS_YAW) ? RATE_200 : RATE_220)));
            state_in    = S_PROP;
         end
         S_PROP: begin
            pf_in    = rd_clr;
            rd_addr  = {KIND_INTEG, axis_ff};
            f_in     = sat(ext_dw(f_ff) + res_w);
            wr_en    = 1'b1;
            wr_addr  = {KIND_FILT, axis_ff};
            wr_data  = f_in;
            mul_k    = lane16(cfg.rate_kp, axis_ff);
            mul_x    = XW'(err);
            state_in = S_DERIV;
         end
         S_DERIV: begin
            i_in     = rd_clr;
            rd_addr  = {KIND_PRC, axis_ff};
            acc_in   = (MW + 1)'(mul_result);
            wr_en    = 1'b1;
            wr_addr  = {KIND_PFILT, axis_ff};
            wr_data  = f_ff;
            mul_k    = lane16(cfg.rate_kd_per_dt, axis_ff);
            mul_x    = XW'(ext_dw(f_ff) - ext_dw(pf_ff));
            state_in = S_INTEG;
         end
         S_INTEG: begin
            // rate command history survives a clear
            prc_in   = signed'(rd_data);
            acc_in   = (MW + 1)'(AW'(acc_ff) + res_w);
            mul_k    = lane16(cfg.rate_ki_dt, axis_ff);
            mul_x    = XW'(err);
            state_in = S_FFWD;
         end
         S_FFWD: begin
            i_in     = sat(clampsym(ext_dw(i_ff) + res_w,
                                    lane16(cfg.integ_limits, axis_ff)));
            wr_en    = 1'b1;
            wr_addr  = {KIND_INTEG, axis_ff};
            wr_data  = i_in;
            mul_k    = lane16(cfg.inertia_per_dt, axis_ff);
            mul_x    = XW'(ext_16(cmd) - ext_dw(prc_ff));
            state_in = S_TORQUE;
         end
         S_TORQUE: begin
            t_in     = sat(clampsym(AW'(acc_ff) + ext_dw(i_ff),
                                    lane16(cfg.torque_limits, axis_ff)));
            ff_in    = mul_result;
            state_in = S_HYBRID;
         end
         S_HYBRID: begin
            if (hybrid) begin
               t_in    = sat(ext_dw(t_ff) + AW'(ff_ff));
               wr_en   = 1'b1;
               wr_addr = {KIND_PRC, axis_ff};
               wr_data = sat(ext_16(cmd));
            end
            state_in = S_COMP;
         end
         S_COMP: begin
            mul_k    = cfg.filter_comp_mode[31:16];
            mul_x    = XW'(t_ff);
            state_in = S_STORE;
         end
         S_STORE: begin
            torque_in[axis_ff] = FIELD_W'(sat(res_w));
            if (axis_ff == AXIS_YAW) begin
               state_in = S_HOLD;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_ORATE;
            end
         end
         S_HOLD: begin
            if (ctrl.take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= AXIS_ROLL;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
      f_ff      <= f_in;
      pf_ff     <= pf_in;
      i_ff      <= i_in;
      prc_ff    <= prc_in;
      t_ff      <= t_in;
      acc_ff    <= acc_in;
      ff_ff     <= ff_in;
      orate_ff  <= orate_in;
      torque_ff <= torque_in;
   end

   assign done   = (state_ff == S_HOLD);
   assign result = {orate_ff[2], orate_ff[1], orate_ff[0],
                    torque_ff[2], torque_ff[1], torque_ff[0]};

endmodule

`default_nettype wire

// ===== sv/cascaded_attitude_rate_pid_top.sv =====
// ----------------------------------------------------------------------------
// cascaded_attitude_rate_pid_top
// Cascaded attitude/rate PID controller, one control tick per request item.
// Ten sequencer steps per axis, roll then pitch then yaw, then the output register.
// A new request is taken only once the last item has moved to the output register,
// as every axis step goes through the single shared multiplier and one-read/one-write state memory.
// Reset: synchronous; configuration registers and controller state read as zero afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_attitude_rate_pid_top
   import carpid_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   // att_err_roll, att_err_pitch, att_err_yaw, rate_roll, rate_pitch, rate_yaw,
   // cmd_roll, cmd_pitch, cmd_yaw
   input  wire  [REQ_DATA_W-1:0]   req_tdata,
   // clear_integrators
   input  wire  [0:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   // torque_roll, torque_pitch, torque_yaw,
   // outer_rate_roll, outer_rate_pitch, outer_rate_yaw
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                     csr_we,
   input  wire  [CSR_IDX_W-1:0]    csr_index,
   input  wire  [CSR_W-1:0]        csr_wdata
);

   localparam int XW = mul_x_width(DATA_WIDTH);
   localparam int MW = mul_res_width(DATA_WIDTH);

   cfg_type               cfg_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic                  clear_ff;
   logic                  busy_ff;
   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   seq_ctrl_type          ctrl;
   logic                  accept;
   logic                  seq_done;
   logic [RSP_DATA_W-1:0] seq_result;

   logic                    wr_en;
   logic [STATE_ADDR_W-1:0] wr_addr;
   logic [DATA_WIDTH-1:0]   wr_data;
   logic [STATE_ADDR_W-1:0] rd_addr;
   logic [DATA_WIDTH-1:0]   rd_data;

   logic [FIELD_W-1:0]    mul_k;
   logic signed [XW-1:0]  mul_x;
   logic                  mul_shift16;
   logic signed [MW-1:0]  mul_result;

   assign req_tready = ~busy_ff;
   assign accept     = req_tvalid & ~busy_ff;

   always_comb begin
      ctrl.start = accept;
      // finished item moves out once the output register is free
      ctrl.take  = seq_done & (~rsp_tvalid_ff | rsp_tready);
      ctrl.clear = clear_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ATT_GAINS:        cfg_ff.att_gains        <= csr_wdata;
            CSR_RATE_KP:          cfg_ff.rate_kp          <= csr_wdata;
            CSR_RATE_KI_DT:       cfg_ff.rate_ki_dt       <= csr_wdata;
            CSR_RATE_KD_PER_DT:   cfg_ff.rate_kd_per_dt   <= csr_wdata;
            CSR_INTEG_LIMITS:     cfg_ff.integ_limits     <= csr_wdata;
            CSR_TORQUE_LIMITS:    cfg_ff.torque_limits    <= csr_wdata;
            CSR_INERTIA_PER_DT:   cfg_ff.inertia_per_dt   <= csr_wdata;
            CSR_FILTER_COMP_MODE: cfg_ff.filter_comp_mode <= csr_wdata[MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (ctrl.take) begin
            busy_ff <= 1'b0;
         end
         if (ctrl.take) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
      if (accept) begin
         in_data_ff <= req_tdata;
         clear_ff   <= req_tuser[0];
      end
      if (ctrl.take) begin
         rsp_tdata_ff <= seq_result;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   carpid_state_ram #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_state_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   carpid_mul_round #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mul_round (
      .clock   (clock),
      .k       (mul_k),
      .x       (mul_x),
      .shift16 (mul_shift16),
      .result  (mul_result)
   );

   carpid_seq #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .cfg         (cfg_ff),
      .in_data     (in_data_ff),
      .done        (seq_done),
      .result      (seq_result),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .mul_k       (mul_k),
      .mul_x       (mul_x),
      .mul_shift16 (mul_shift16),
      .mul_result  (mul_result)
   );

endmodule

`default_nettype wire
